// ----- hdl/r4bf_pkg.sv -----
// types and constants shared by the radix-4 butterfly block
// no dependencies
`default_nettype none

package r4bf_pkg;

    localparam int SLOT_W  = 18;
    localparam int HALF_W  = 16;
    localparam int TW_FRAC = 15;

    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic        apply_twiddle;
    } in_word_t;

    typedef struct packed {
        logic [35:0] y0;
        logic [35:0] y1;
        logic [35:0] y2;
        logic [35:0] y3;
        logic        saturated;
    } out_word_t;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

`default_nettype wire

// ----- hdl/r4bf_cmul.sv -----
// three-stage twiddle multiplier: products, round sum, saturate and select
// uses r4bf_pkg
`default_nettype none

module r4bf_cmul #(
    parameter int OUT_PART_W = 18
) (
    input  wire                           clk,
    input  r4bf_pkg::stage_en_t           en,
    input  wire signed [OUT_PART_W-1:0]   yr,
    input  wire signed [OUT_PART_W-1:0]   yi,
    input  wire        [31:0]             w,
    input  wire                           apply,
    output logic       [2*r4bf_pkg::SLOT_W-1:0] slot,
    output logic                          sat
);
    import r4bf_pkg::*;

    localparam int PROD_W = OUT_PART_W + HALF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - TW_FRAC;
    localparam int RND    = 1 << (TW_FRAC - 1);

    logic signed [HALF_W-1:0]     wr;
    logic signed [HALF_W-1:0]     wi;

    logic signed [PROD_W-1:0]     ac_reg, bd_reg, ad_reg, bc_reg;
    logic signed [OUT_PART_W-1:0] yr3_reg, yi3_reg;
    logic                         apply3_reg;

    logic signed [SUM_W-1:0]      re_sum_reg, im_sum_reg;
    logic signed [SUM_W-1:0]      re_sum_next, im_sum_next;
    logic signed [OUT_PART_W-1:0] yr4_reg, yi4_reg;
    logic                         apply4_reg;

    logic signed [Q_W-1:0]        re_q, im_q;
    logic                         re_ovf, im_ovf;
    logic signed [OUT_PART_W-1:0] re_fin, im_fin;
    logic signed [OUT_PART_W-1:0] re_sel, im_sel;
    logic [2*SLOT_W-1:0]          slot_reg, slot_next;
    logic                         sat_reg, sat_next;

    localparam logic signed [OUT_PART_W-1:0] MAX_V = {1'b0, {(OUT_PART_W-1){1'b1}}};
    localparam logic signed [OUT_PART_W-1:0] MIN_V = {1'b1, {(OUT_PART_W-1){1'b0}}};

    assign wr = $signed(w[31:16]);
    assign wi = $signed(w[15:0]);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            ac_reg     <= PROD_W'(yr) * PROD_W'(wr);
            bd_reg     <= PROD_W'(yi) * PROD_W'(wi);
            ad_reg     <= PROD_W'(yr) * PROD_W'(wi);
            bc_reg     <= PROD_W'(yi) * PROD_W'(wr);
            yr3_reg    <= yr;
            yi3_reg    <= yi;
            apply3_reg <= apply;
        end
    end

    always_comb
    begin
        re_sum_next = SUM_W'(ac_reg) - SUM_W'(bd_reg) + SUM_W'(RND);
        im_sum_next = SUM_W'(ad_reg) + SUM_W'(bc_reg) + SUM_W'(RND);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            re_sum_reg <= re_sum_next;
            im_sum_reg <= im_sum_next;
            yr4_reg    <= yr3_reg;
            yi4_reg    <= yi3_reg;
            apply4_reg <= apply3_reg;
        end
    end

    always_comb
    begin
        re_q   = $signed(re_sum_reg[SUM_W-1:TW_FRAC]);
        im_q   = $signed(im_sum_reg[SUM_W-1:TW_FRAC]);
        re_ovf = !(&re_q[Q_W-1:OUT_PART_W-1]) && (|re_q[Q_W-1:OUT_PART_W-1]);
        im_ovf = !(&im_q[Q_W-1:OUT_PART_W-1]) && (|im_q[Q_W-1:OUT_PART_W-1]);
        re_fin = re_ovf ? (re_q[Q_W-1] ? MIN_V : MAX_V) : re_q[OUT_PART_W-1:0];
        im_fin = im_ovf ? (im_q[Q_W-1] ? MIN_V : MAX_V) : im_q[OUT_PART_W-1:0];
        re_sel = apply4_reg ? re_fin : yr4_reg;
        im_sel = apply4_reg ? im_fin : yi4_reg;
        slot_next = {SLOT_W'(re_sel), SLOT_W'(im_sel)};
        sat_next  = apply4_reg && (re_ovf || im_ovf);
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            slot_reg <= slot_next;
            sat_reg  <= sat_next;
        end
    end

    assign slot = slot_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/radix4_butterfly_twiddle_top.sv -----
// radix-4 decimation-in-frequency butterfly with optional twiddle multiply
// uses r4bf_pkg and r4bf_cmul
`default_nettype none

// Takes one word of four complex samples and three twiddles per clock
// while sample_stall is low, and returns one word of four butterfly
// outputs. The five stages are: first sums, butterfly outputs, twiddle
// products, rounding add, saturation and select; the product, round and
// saturate path of each of the three twiddle multipliers sets the depth.
// Sustained rate is one word per clock while result_stall is low. A stall
// on the result side holds full stages only; empty ones keep filling.
module radix4_butterfly_twiddle_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  sample_valid,
    output logic                 sample_stall,
    input  r4bf_pkg::in_word_t   sample,
    output logic                 result_valid,
    input  wire                  result_stall,
    output r4bf_pkg::out_word_t  result
);
    import r4bf_pkg::*;

    localparam int PW     = (SAMPLE_WIDTH > 16) ? 16 : SAMPLE_WIDTH;
    localparam int BW     = PW + 1;
    localparam int YW     = PW + 2;
    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] rdy;
    stage_en_t         en;

    logic [31:0]           xin [4];
    logic signed [PW-1:0]  xr [4];
    logic signed [PW-1:0]  xi [4];

    logic signed [BW-1:0]  ar_reg, ai_reg, cr_reg, ci_reg;
    logic signed [BW-1:0]  br_reg, bi_reg, dr_reg, di_reg;
    logic [31:0]           w1a_reg, w2a_reg, w3a_reg;
    logic                  apply1_reg;

    logic signed [YW-1:0]  yr_reg [4];
    logic signed [YW-1:0]  yi_reg [4];
    logic signed [YW-1:0]  yr_next [4];
    logic signed [YW-1:0]  yi_next [4];
    logic [31:0]           w1b_reg, w2b_reg, w3b_reg;
    logic                  apply2_reg;

    logic [2*SLOT_W-1:0]   y0_3_reg, y0_4_reg, y0_5_reg;
    logic [2*SLOT_W-1:0]   slot1, slot2, slot3;
    logic                  sat1, sat2, sat3;

    // handshake: a stage takes a word when it is empty or its word moves on
    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? sample_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sample_stall = !rdy[0];
    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];
    assign en.s5 = rdy[4];

    // stage 1: unpack and first sums
    assign xin[0] = sample.x0;
    assign xin[1] = sample.x1;
    assign xin[2] = sample.x2;
    assign xin[3] = sample.x3;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            xr[k] = $signed(xin[k][HALF_W+PW-1:HALF_W]);
            xi[k] = $signed(xin[k][PW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ar_reg     <= BW'(xr[0]) + BW'(xr[2]);
            ai_reg     <= BW'(xi[0]) + BW'(xi[2]);
            cr_reg     <= BW'(xr[1]) + BW'(xr[3]);
            ci_reg     <= BW'(xi[1]) + BW'(xi[3]);
            br_reg     <= BW'(xr[0]) - BW'(xr[2]);
            bi_reg     <= BW'(xi[0]) - BW'(xi[2]);
            dr_reg     <= BW'(xr[1]) - BW'(xr[3]);
            di_reg     <= BW'(xi[1]) - BW'(xi[3]);
            w1a_reg    <= sample.w1;
            w2a_reg    <= sample.w2;
            w3a_reg    <= sample.w3;
            apply1_reg <= sample.apply_twiddle;
        end
    end

    // stage 2: butterfly outputs
    always_comb
    begin
        yr_next[0] = YW'(ar_reg) + YW'(cr_reg);
        yi_next[0] = YW'(ai_reg) + YW'(ci_reg);
        yr_next[1] = YW'(br_reg) + YW'(di_reg);
        yi_next[1] = YW'(bi_reg) - YW'(dr_reg);
        yr_next[2] = YW'(ar_reg) - YW'(cr_reg);
        yi_next[2] = YW'(ai_reg) - YW'(ci_reg);
        yr_next[3] = YW'(br_reg) - YW'(di_reg);
        yi_next[3] = YW'(bi_reg) + YW'(dr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < 4; k++)
            begin
                yr_reg[k] <= yr_next[k];
                yi_reg[k] <= yi_next[k];
            end
            w1b_reg    <= w1a_reg;
            w2b_reg    <= w2a_reg;
            w3b_reg    <= w3a_reg;
            apply2_reg <= apply1_reg;
        end
    end

    // stages 3 to 5: output 0 passes through, outputs 1 to 3 get twiddles if apply_twiddle
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            y0_3_reg <= {SLOT_W'(yr_reg[0]), SLOT_W'(yi_reg[0])};
        end
        if (en.s4)
        begin
            y0_4_reg <= y0_3_reg;
        end
        if (en.s5)
        begin
            y0_5_reg <= y0_4_reg;
        end
    end

    r4bf_cmul #(
        .OUT_PART_W (YW)
    ) u_cmul1 (
        .clk   (clk),
        .en    (en),
        .yr    (yr_reg[1]),
        .yi    (yi_reg[1]),
        .w     (w1b_reg),
        .apply (apply2_reg),
        .slot  (slot1),
        .sat   (sat1)
    );

    r4bf_cmul #(
        .OUT_PART_W (YW)
    ) u_cmul2 (
        .clk   (clk),
        .en    (en),
        .yr    (yr_reg[2]),
        .yi    (yi_reg[2]),
        .w     (w2b_reg),
        .apply (apply2_reg),
        .slot  (slot2),
        .sat   (sat2)
    );

    r4bf_cmul #(
        .OUT_PART_W (YW)
    ) u_cmul3 (
        .clk   (clk),
        .en    (en),
        .yr    (yr_reg[3]),
        .yi    (yi_reg[3]),
        .w     (w3b_reg),
        .apply (apply2_reg),
        .slot  (slot3),
        .sat   (sat3)
    );

    assign result_valid     = vld_reg[STAGES-1];
    assign result.y0        = y0_5_reg;
    assign result.y1        = slot1;
    assign result.y2        = slot2;
    assign result.y3        = slot3;
    assign result.saturated = sat1 || sat2 || sat3;

endmodule

`default_nettype wire
